@@ hw/rtl/stok_pkg.sv @@
// stok_pkg: shared types, constants and helper functions of the source tokenizer
// used by stok_lexer, source_tokenizer and stok_checker; depends on nothing
`default_nettype none

package stok_pkg;

   localparam int OFFSET_BITS = 24;
   localparam int LINE_BITS   = 24;
   localparam int FIELD_BITS  = 24;

   localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;
   localparam logic [LINE_BITS-1:0]   LINE_MAX   = '1;
   localparam logic [FIELD_BITS-1:0]  FIELD_MAX  = '1;
   localparam logic [LINE_BITS-1:0]   LINE_FIRST = LINE_BITS'(1);

   localparam int REQ_TDATA_BITS = 8;
   localparam int RSP_TDATA_BITS = 80;
   localparam int RSP_TUSER_BITS = 5;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
   localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

   // characters the lexer looks at
   localparam logic [7:0] CH_TAB        = 8'h09;
   localparam logic [7:0] CH_LF         = 8'h0A;
   localparam logic [7:0] CH_CR         = 8'h0D;
   localparam logic [7:0] CH_SPACE      = 8'h20;
   localparam logic [7:0] CH_QUOTE      = 8'h22;
   localparam logic [7:0] CH_LPAR       = 8'h28;
   localparam logic [7:0] CH_RPAR       = 8'h29;
   localparam logic [7:0] CH_MINUS      = 8'h2D;
   localparam logic [7:0] CH_0          = 8'h30;
   localparam logic [7:0] CH_9          = 8'h39;
   localparam logic [7:0] CH_COLON      = 8'h3A;
   localparam logic [7:0] CH_SEMI       = 8'h3B;
   localparam logic [7:0] CH_EQUAL      = 8'h3D;
   localparam logic [7:0] CH_GT         = 8'h3E;
   localparam logic [7:0] CH_UPPER_A    = 8'h41;
   localparam logic [7:0] CH_UPPER_Z    = 8'h5A;
   localparam logic [7:0] CH_LBRACK     = 8'h5B;
   localparam logic [7:0] CH_BACKSLASH  = 8'h5C;
   localparam logic [7:0] CH_RBRACK     = 8'h5D;
   localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CH_LOWER_A    = 8'h61;
   localparam logic [7:0] CH_LOWER_E    = 8'h65;
   localparam logic [7:0] CH_LOWER_I    = 8'h69;
   localparam logic [7:0] CH_LOWER_L    = 8'h6C;
   localparam logic [7:0] CH_LOWER_N    = 8'h6E;
   localparam logic [7:0] CH_LOWER_T    = 8'h74;
   localparam logic [7:0] CH_LOWER_Z    = 8'h7A;

   typedef enum logic [2:0] {
      MODE_IDLE   = 3'd0,
      MODE_IDENT  = 3'd1,
      MODE_NUMBER = 3'd2,
      MODE_STRING = 3'd3,
      MODE_COLON  = 3'd4,
      MODE_EQUAL  = 3'd5,
      MODE_MINUS  = 3'd6
   } mode_type;

   // keyword prefix tracking
   typedef enum logic [2:0] {
      KW_NONE = 3'd0,
      KW_L    = 3'd1,
      KW_LE   = 3'd2,
      KW_LET  = 3'd3,
      KW_I    = 3'd4,
      KW_IN   = 3'd5
   } keyword_type;

   typedef enum logic [4:0] {
      KIND_IDENT   = 5'd0,
      KIND_NUMBER  = 5'd1,
      KIND_STRING  = 5'd2,
      KIND_LET     = 5'd3,
      KIND_IN      = 5'd4,
      KIND_ASSIGN  = 5'd5,
      KIND_EQUALS  = 5'd6,
      KIND_ARROW   = 5'd7,
      KIND_SEMI    = 5'd8,
      KIND_BSLASH  = 5'd9,
      KIND_LPAREN  = 5'd10,
      KIND_RPAREN  = 5'd11,
      KIND_LSQUARE = 5'd12,
      KIND_RSQUARE = 5'd13,
      KIND_COLON   = 5'd14,
      KIND_DCOLON  = 5'd15,
      KIND_BAD     = 5'd16
   } token_kind_type;

   typedef enum logic [1:0] {
      ERR_NONE    = 2'd0,
      ERR_UNKNOWN = 2'd1,
      ERR_UNTERM  = 2'd2
   } error_code_type;

   localparam logic ITEM_BYTE = 1'b0;
   localparam logic ITEM_END  = 1'b1;

   typedef struct packed {
      mode_type               mode;
      keyword_type            kw;
      logic [OFFSET_BITS-1:0] offset;
      logic [LINE_BITS-1:0]   line;
      logic [OFFSET_BITS-1:0] pend_start;
      logic [LINE_BITS-1:0]   pend_line;
   } lex_state_type;

   typedef struct packed {
      token_kind_type        kind;
      error_code_type        err;
      logic [FIELD_BITS-1:0] start;
      logic [FIELD_BITS-1:0] len;
      logic [FIELD_BITS-1:0] line;
      logic                  last;
   } result_type;

   // results of one step, first in r0
   typedef struct packed {
      logic [1:0] count;
      result_type r0;
      result_type r1;
   } step_type;

   function automatic logic is_space(logic [7:0] c);
      return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
   endfunction

   function automatic logic is_alpha(logic [7:0] c);
      return ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z)) ||
             ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z));
   endfunction

   function automatic logic is_digit(logic [7:0] c);
      return (c >= CH_0) && (c <= CH_9);
   endfunction

   function automatic logic [OFFSET_BITS-1:0] offset_inc(logic [OFFSET_BITS-1:0] o);
      return (o == OFFSET_MAX) ? o : o + OFFSET_BITS'(1);
   endfunction

   function automatic token_kind_type single_kind(logic [7:0] c);
      token_kind_type k;
      case (c)
         CH_LPAR:      k = KIND_LPAREN;
         CH_RPAR:      k = KIND_RPAREN;
         CH_LBRACK:    k = KIND_LSQUARE;
         CH_RBRACK:    k = KIND_RSQUARE;
         CH_SEMI:      k = KIND_SEMI;
         CH_BACKSLASH: k = KIND_BSLASH;
         default:      k = KIND_BAD;
      endcase
      return k;
   endfunction

   function automatic result_type make_result(token_kind_type k, error_code_type e,
                                              logic [OFFSET_BITS-1:0] start,
                                              logic [OFFSET_BITS-1:0] len,
                                              logic [LINE_BITS-1:0] line);
      logic [63:0] start_w;
      logic [63:0] len_w;
      logic [63:0] line_w;
      result_type  r;
      start_w = 64'(start);
      len_w   = 64'(len);
      line_w  = 64'(line);
      r.kind  = k;
      r.err   = e;
      r.start = start_w[FIELD_BITS-1:0];
      r.len   = (len_w > 64'(FIELD_MAX)) ? FIELD_MAX : len_w[FIELD_BITS-1:0];
      r.line  = line_w[FIELD_BITS-1:0];
      r.last  = 1'b0;
      return r;
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/stok_lexer.sv @@
// stok_lexer: next-state and token logic of the tokenizer for one input beat
// purely combinational; depends on stok_pkg
`default_nettype none

module stok_lexer (
   input  wire stok_pkg::lex_state_type st,
   input  wire logic                    item_kind,
   input  wire logic [7:0]              item_byte,
   output stok_pkg::lex_state_type      st_next,
   output stok_pkg::step_type           step
);

   stok_pkg::lex_state_type       nx;
   stok_pkg::result_type          res_a;
   stok_pkg::result_type          res_b;
   stok_pkg::result_type          flush_res;
   logic                          flush_en;
   logic                          a_en;
   logic                          b_en;
   logic                          do_start;
   logic [stok_pkg::OFFSET_BITS-1:0] off_inc;
   logic [stok_pkg::OFFSET_BITS-1:0] pend_len;
   logic [stok_pkg::OFFSET_BITS-1:0] pend_len_inc;
   logic [7:0]                    want;
   stok_pkg::token_kind_type      pair_kind;
   stok_pkg::token_kind_type      flush_kind;
   stok_pkg::error_code_type      flush_err;
   stok_pkg::token_kind_type      sk;
   stok_pkg::error_code_type      sk_err;

   assign off_inc      = stok_pkg::offset_inc(st.offset);
   assign pend_len     = st.offset - st.pend_start;
   assign pend_len_inc = off_inc - st.pend_start;

   // what the pending token becomes when cut short
   always_comb begin
      flush_en   = 1'b1;
      flush_kind = stok_pkg::KIND_IDENT;
      flush_err  = stok_pkg::ERR_NONE;
      case (st.mode)
         stok_pkg::MODE_IDENT: begin
            if (st.kw == stok_pkg::KW_LET) begin
               flush_kind = stok_pkg::KIND_LET;
            end else if (st.kw == stok_pkg::KW_IN) begin
               flush_kind = stok_pkg::KIND_IN;
            end
         end
         stok_pkg::MODE_NUMBER: flush_kind = stok_pkg::KIND_NUMBER;
         stok_pkg::MODE_STRING: begin
            flush_kind = stok_pkg::KIND_BAD;
            flush_err  = stok_pkg::ERR_UNTERM;
         end
         stok_pkg::MODE_COLON: flush_kind = stok_pkg::KIND_COLON;
         stok_pkg::MODE_EQUAL: flush_kind = stok_pkg::KIND_ASSIGN;
         stok_pkg::MODE_MINUS: begin
            flush_kind = stok_pkg::KIND_BAD;
            flush_err  = stok_pkg::ERR_UNKNOWN;
         end
         default: flush_en = 1'b0;
      endcase
      flush_res = stok_pkg::make_result(flush_kind, flush_err, st.pend_start, pend_len,
                                        st.pend_line);
   end

   // second character of a two-character operator
   always_comb begin
      case (st.mode)
         stok_pkg::MODE_COLON: begin
            want      = stok_pkg::CH_COLON;
            pair_kind = stok_pkg::KIND_DCOLON;
         end
         stok_pkg::MODE_EQUAL: begin
            want      = stok_pkg::CH_EQUAL;
            pair_kind = stok_pkg::KIND_EQUALS;
         end
         default: begin
            want      = stok_pkg::CH_GT;
            pair_kind = stok_pkg::KIND_ARROW;
         end
      endcase
   end

   assign sk = stok_pkg::single_kind(item_byte);

   always_comb begin
      sk_err = stok_pkg::ERR_NONE;
      if (sk == stok_pkg::KIND_BAD) begin
         sk_err = stok_pkg::ERR_UNKNOWN;
      end
   end

   always_comb begin
      nx       = st;
      a_en     = 1'b0;
      b_en     = 1'b0;
      do_start = 1'b0;
      res_a    = flush_res;
      res_b    = stok_pkg::make_result(sk, sk_err, st.offset, stok_pkg::OFFSET_BITS'(1),
                                       st.line);
      if (item_kind == stok_pkg::ITEM_END) begin
         a_en      = flush_en;
         nx.mode   = stok_pkg::MODE_IDLE;
         nx.kw     = stok_pkg::KW_NONE;
         nx.offset = '0;
         nx.line   = stok_pkg::LINE_FIRST;
      end else begin
         case (st.mode)
            stok_pkg::MODE_IDENT: begin
               if (stok_pkg::is_alpha(item_byte) || stok_pkg::is_digit(item_byte) ||
                   item_byte == stok_pkg::CH_UNDERSCORE) begin
                  if (st.kw == stok_pkg::KW_L && item_byte == stok_pkg::CH_LOWER_E) begin
                     nx.kw = stok_pkg::KW_LE;
                  end else if (st.kw == stok_pkg::KW_LE &&
                               item_byte == stok_pkg::CH_LOWER_T) begin
                     nx.kw = stok_pkg::KW_LET;
                  end else if (st.kw == stok_pkg::KW_I &&
                               item_byte == stok_pkg::CH_LOWER_N) begin
                     nx.kw = stok_pkg::KW_IN;
                  end else begin
                     nx.kw = stok_pkg::KW_NONE;
                  end
                  nx.offset = off_inc;
               end else begin
                  a_en     = 1'b1;
                  do_start = 1'b1;
               end
            end
            stok_pkg::MODE_NUMBER: begin
               if (stok_pkg::is_digit(item_byte)) begin
                  nx.offset = off_inc;
               end else begin
                  a_en     = 1'b1;
                  do_start = 1'b1;
               end
            end
            stok_pkg::MODE_STRING: begin
               nx.offset = off_inc;
               if (item_byte == stok_pkg::CH_QUOTE) begin
                  a_en    = 1'b1;
                  res_a   = stok_pkg::make_result(stok_pkg::KIND_STRING, stok_pkg::ERR_NONE,
                               st.pend_start, pend_len_inc, st.pend_line);
                  nx.mode = stok_pkg::MODE_IDLE;
               end
            end
            stok_pkg::MODE_COLON, stok_pkg::MODE_EQUAL, stok_pkg::MODE_MINUS: begin
               if (item_byte == want) begin
                  nx.offset = off_inc;
                  a_en      = 1'b1;
                  res_a     = stok_pkg::make_result(pair_kind, stok_pkg::ERR_NONE,
                                 st.pend_start, pend_len_inc, st.pend_line);
                  nx.mode   = stok_pkg::MODE_IDLE;
               end else begin
                  a_en     = 1'b1;
                  do_start = 1'b1;
               end
            end
            default: do_start = 1'b1;
         endcase

         // first byte of a new token; offset and line are still the current ones
         if (do_start) begin
            nx.mode   = stok_pkg::MODE_IDLE;
            nx.offset = off_inc;
            if (stok_pkg::is_space(item_byte)) begin
               if (item_byte == stok_pkg::CH_LF && st.line != stok_pkg::LINE_MAX) begin
                  nx.line = st.line + stok_pkg::LINE_BITS'(1);
               end
            end else if (stok_pkg::is_alpha(item_byte) ||
                         item_byte == stok_pkg::CH_UNDERSCORE ||
                         stok_pkg::is_digit(item_byte) ||
                         item_byte == stok_pkg::CH_QUOTE ||
                         item_byte == stok_pkg::CH_COLON ||
                         item_byte == stok_pkg::CH_EQUAL ||
                         item_byte == stok_pkg::CH_MINUS) begin
               nx.pend_start = st.offset;
               nx.pend_line  = st.line;
               if (stok_pkg::is_digit(item_byte)) begin
                  nx.mode = stok_pkg::MODE_NUMBER;
               end else if (item_byte == stok_pkg::CH_QUOTE) begin
                  nx.mode = stok_pkg::MODE_STRING;
               end else if (item_byte == stok_pkg::CH_COLON) begin
                  nx.mode = stok_pkg::MODE_COLON;
               end else if (item_byte == stok_pkg::CH_EQUAL) begin
                  nx.mode = stok_pkg::MODE_EQUAL;
               end else if (item_byte == stok_pkg::CH_MINUS) begin
                  nx.mode = stok_pkg::MODE_MINUS;
               end else begin
                  nx.mode = stok_pkg::MODE_IDENT;
                  if (item_byte == stok_pkg::CH_LOWER_L) begin
                     nx.kw = stok_pkg::KW_L;
                  end else if (item_byte == stok_pkg::CH_LOWER_I) begin
                     nx.kw = stok_pkg::KW_I;
                  end else begin
                     nx.kw = stok_pkg::KW_NONE;
                  end
               end
            end else begin
               b_en = 1'b1;
            end
         end
      end
   end

   // order the results and mark the final one
   always_comb begin
      st_next    = nx;
      step.r0    = res_a;
      step.r1    = res_b;
      step.count = 2'd0;
      if (a_en && b_en) begin
         step.count   = 2'd2;
         step.r1.last = 1'b1;
      end else if (a_en) begin
         step.count   = 2'd1;
         step.r0.last = 1'b1;
      end else if (b_en) begin
         step.count   = 2'd1;
         step.r0      = res_b;
         step.r0.last = 1'b1;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/source_tokenizer.sv @@
// source_tokenizer: top level, input register, lexer state and result queue
// depends on stok_pkg and stok_lexer
//
// usage
//   req channel: one beat per source byte (req_tuser low, byte in req_tdata) or an
//   end-of-input beat (req_tuser high) that flushes the pending token and restarts
//   offset and line counting for a fresh source
//   rsp channel: one beat per token; kind in rsp_tuser, rsp_tlast marks the final
//   token caused by one req beat; a req beat gives zero, one or two tokens
//   path: a taken beat waits in the input register until the queue has room, is
//   then lexed, and its tokens are written to the queue and offered on rsp
//   throughput: one req beat per cycle while the queue has room, set by the single
//   registered lexer step; the rsp side drains one token per cycle from a four-entry
//   queue, so beats that give two tokens hold req back only when the queue fills
//   reset: synchronous, clears the lexer to idle, offset 0, line 1 and empties
//   the queue and the input register
//   stall: with rsp_tready low the queue fills and req_tready drops once fewer
//   than two entries are free; nothing is lost or repeated
`default_nettype none

module source_tokenizer (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output      logic                                 req_tready,
   // [7:0] source_byte
   input  wire logic [stok_pkg::REQ_TDATA_BITS-1:0]  req_tdata,
   // [0] kind
   input  wire logic                                 req_tuser,
   output      logic                                 rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // [1:0] error_code, [25:2] start_offset, [49:26] token_length,
   // [73:50] start_line, [79:74] zero
   output      logic [stok_pkg::RSP_TDATA_BITS-1:0]  rsp_tdata,
   // [4:0] token_kind
   output      logic [stok_pkg::RSP_TUSER_BITS-1:0]  rsp_tuser,
   // last_of_run
   output      logic                                 rsp_tlast
);

   logic                              in_valid_ff;
   logic                              in_valid_in;
   logic                              in_kind_ff;
   logic [7:0]                        in_byte_ff;
   stok_pkg::lex_state_type           st_ff;
   stok_pkg::lex_state_type           st_in;
   stok_pkg::step_type                step;
   stok_pkg::result_type              fifo_ff [stok_pkg::FIFO_DEPTH];
   stok_pkg::result_type              head;
   logic [stok_pkg::FIFO_AW-1:0]      wr_ff;
   logic [stok_pkg::FIFO_AW-1:0]      wr_in;
   logic [stok_pkg::FIFO_AW-1:0]      rd_ff;
   logic [stok_pkg::FIFO_AW-1:0]      rd_in;
   logic [stok_pkg::FIFO_CW-1:0]      count_ff;
   logic [stok_pkg::FIFO_CW-1:0]      count_in;
   logic                              step_go;
   logic                              req_take;
   logic                              pop;

   stok_lexer u_lexer (
      .st        (st_ff),
      .item_kind (in_kind_ff),
      .item_byte (in_byte_ff),
      .st_next   (st_in),
      .step      (step)
   );

   // room for two tokens before a beat is lexed
   assign step_go    = in_valid_ff &&
                       (count_ff <= stok_pkg::FIFO_CW'(stok_pkg::FIFO_DEPTH - 2));
   assign req_tready = !in_valid_ff || step_go;
   assign req_take   = req_tvalid && req_tready;
   assign in_valid_in = req_take || (in_valid_ff && !step_go);

   assign rsp_tvalid = (count_ff != '0);
   assign pop        = rsp_tvalid && rsp_tready;
   assign head       = fifo_ff[rd_ff];

   assign wr_in    = step_go ? wr_ff + stok_pkg::FIFO_AW'(step.count) : wr_ff;
   assign rd_in    = pop ? rd_ff + stok_pkg::FIFO_AW'(1) : rd_ff;
   assign count_in = count_ff + (step_go ? stok_pkg::FIFO_CW'(step.count) : '0)
                     - stok_pkg::FIFO_CW'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         st_ff.mode       <= stok_pkg::MODE_IDLE;
         st_ff.kw         <= stok_pkg::KW_NONE;
         st_ff.offset     <= '0;
         st_ff.line       <= stok_pkg::LINE_FIRST;
         st_ff.pend_start <= '0;
         st_ff.pend_line  <= stok_pkg::LINE_FIRST;
         wr_ff       <= '0;
         rd_ff       <= '0;
         count_ff    <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (step_go) begin
            st_ff <= st_in;
         end
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_kind_ff <= req_tuser;
         in_byte_ff <= req_tdata[7:0];
      end
      if (step_go && step.count != 2'd0) begin
         fifo_ff[wr_ff] <= step.r0;
      end
      if (step_go && step.count == 2'd2) begin
         fifo_ff[wr_ff + stok_pkg::FIFO_AW'(1)] <= step.r1;
      end
   end

   assign rsp_tdata = {6'b0, head.line, head.len, head.start, head.err};
   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.last;

endmodule

`default_nettype wire

@@ hw/rtl/stok_checker.sv @@
// stok_checker: port-level checks of the source tokenizer, bound to the top level
// depends on stok_pkg and source_tokenizer
`default_nettype none

module stok_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_tvalid,
   input wire logic                                req_tready,
   input wire logic [stok_pkg::REQ_TDATA_BITS-1:0] req_tdata,
   input wire logic                                req_tuser,
   input wire logic                                rsp_tvalid,
   input wire logic                                rsp_tready,
   input wire logic [stok_pkg::RSP_TDATA_BITS-1:0] rsp_tdata,
   input wire logic [stok_pkg::RSP_TUSER_BITS-1:0] rsp_tuser,
   input wire logic                                rsp_tlast
);

   // a stalled token beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("rsp beat changed while stalled");

   // error code present exactly on error tokens
   a_err_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |->
         ((rsp_tuser == stok_pkg::KIND_BAD) == (rsp_tdata[1:0] != stok_pkg::ERR_NONE)))
      else $error("error code does not match token kind");

   // lines count from one
   a_line_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[73:50] != '0)
      else $error("token on line zero");

   // nothing is offered right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("queue not empty after reset");

endmodule

bind source_tokenizer stok_checker u_stok_checker (.*);

`default_nettype wire

@@ sim/tb_source_tokenizer.sv @@
// tb_source_tokenizer: self-checking bench for the streaming source tokenizer, a typed
// directed script followed by random token-shaped byte streams with idling and back-pressure
// depends on stok_pkg and source_tokenizer
module tb_source_tokenizer;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SCRIPT_ROWS  = 26;
   localparam int RANDOM_BEATS = 1300;
   localparam int CALM_BEATS   = 150;
   localparam int HOLD_AT      = 400;
   localparam int HOLD_CYCLES  = 60;
   localparam int PAUSE_AT     = 800;
   localparam int DRAIN_CYCLES = 16;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic                             eoi;
      logic [7:0]                       ch;
      logic                             typed;
      stok_pkg::token_kind_type         kind;
      stok_pkg::error_code_type         err;
      logic [stok_pkg::OFFSET_BITS-1:0] start;
   } beat_type;

   // typed rows are single-byte tokens on line 1 with length 1
   localparam beat_type SCRIPT [SCRIPT_ROWS] = '{
      '{stok_pkg::ITEM_BYTE, 8'hFF, 1'b1,
        stok_pkg::KIND_BAD, stok_pkg::ERR_UNKNOWN, 24'd0},
      '{stok_pkg::ITEM_BYTE, 8'h00, 1'b1,
        stok_pkg::KIND_BAD, stok_pkg::ERR_UNKNOWN, 24'd1},
      '{stok_pkg::ITEM_BYTE, stok_pkg::CH_LPAR, 1'b1,
        stok_pkg::KIND_LPAREN, stok_pkg::ERR_NONE, 24'd2},
      '{stok_pkg::ITEM_BYTE, stok_pkg::CH_RPAR, 1'b1,
        stok_pkg::KIND_RPAREN, stok_pkg::ERR_NONE, 24'd3},
      '{stok_pkg::ITEM_BYTE, stok_pkg::CH_LBRACK, 1'b1,
        stok_pkg::KIND_LSQUARE, stok_pkg::ERR_NONE, 24'd4},
      '{stok_pkg::ITEM_BYTE, stok_pkg::CH_RBRACK, 1'b1,
        stok_pkg::KIND_RSQUARE, stok_pkg::ERR_NONE, 24'd5},
      '{stok_pkg::ITEM_BYTE, stok_pkg::CH_SEMI, 1'b1,
        stok_pkg::KIND_SEMI, stok_pkg::ERR_NONE, 24'd6},
      '{stok_pkg::ITEM_BYTE, stok_pkg::CH_BACKSLASH, 1'b1,
        stok_pkg::KIND_BSLASH, stok_pkg::ERR_NONE, 24'd7},
      '{stok_pkg::ITEM_BYTE, stok_pkg::CH_LF, 1'b0,
        stok_pkg::KIND_IDENT, stok_pkg::ERR_NONE, 24'd0},
      '{stok_pkg::ITEM_BYTE, stok_pkg::CH_LOWER_L, 1'b0,
        stok_pkg::KIND_IDENT, stok_pkg::ERR_NONE, 24'd0},
      '{stok_pkg::ITEM_BYTE, stok_pkg::CH_LOWER_E, 1'b0,
        stok_pkg::KIND_IDENT, stok_pkg::ERR_NONE, 24'd0},
      '{stok_pkg::ITEM_BYTE, stok_pkg::CH_LOWER_T, 1'b0,
        stok_pkg::KIND_IDENT, stok_pkg::ERR_NONE, 24'd0},
      '{stok_pkg::ITEM_BYTE, stok_pkg::CH_SPACE, 1'b0,
        stok_pkg::KIND_IDENT, stok_pkg::ERR_NONE, 24'd0},
      '{stok_pkg::ITEM_BYTE, stok_pkg::CH_LOWER_I, 1'b0,
        stok_pkg::KIND_IDENT, stok_pkg::ERR_NONE, 24'd0},
      '{stok_pkg::ITEM_BYTE, stok_pkg::CH_LOWER_N, 1'b0,
        stok_pkg::KIND_IDENT, stok_pkg::ERR_NONE, 24'd0},
      '{stok_pkg::ITEM_BYTE, stok_pkg::CH_EQUAL, 1'b0,
        stok_pkg::KIND_IDENT, stok_pkg::ERR_NONE, 24'd0},
      '{stok_pkg::ITEM_BYTE, stok_pkg::CH_EQUAL, 1'b0,
        stok_pkg::KIND_IDENT, stok_pkg::ERR_NONE, 24'd0},
      '{stok_pkg::ITEM_BYTE, stok_pkg::CH_COLON, 1'b0,
        stok_pkg::KIND_IDENT, stok_pkg::ERR_NONE, 24'd0},
      '{stok_pkg::ITEM_BYTE, stok_pkg::CH_9, 1'b0,
        stok_pkg::KIND_IDENT, stok_pkg::ERR_NONE, 24'd0},
      '{stok_pkg::ITEM_BYTE, stok_pkg::CH_MINUS, 1'b0,
        stok_pkg::KIND_IDENT, stok_pkg::ERR_NONE, 24'd0},
      '{stok_pkg::ITEM_BYTE, stok_pkg::CH_GT, 1'b0,
        stok_pkg::KIND_IDENT, stok_pkg::ERR_NONE, 24'd0},
      '{stok_pkg::ITEM_BYTE, stok_pkg::CH_MINUS, 1'b0,
        stok_pkg::KIND_IDENT, stok_pkg::ERR_NONE, 24'd0},
      '{stok_pkg::ITEM_BYTE, stok_pkg::CH_QUOTE, 1'b0,
        stok_pkg::KIND_IDENT, stok_pkg::ERR_NONE, 24'd0},
      '{stok_pkg::ITEM_BYTE, stok_pkg::CH_LF, 1'b0,
        stok_pkg::KIND_IDENT, stok_pkg::ERR_NONE, 24'd0},
      '{stok_pkg::ITEM_END, 8'hA5, 1'b0,
        stok_pkg::KIND_IDENT, stok_pkg::ERR_NONE, 24'd0},
      '{stok_pkg::ITEM_END, 8'h5A, 1'b0,
        stok_pkg::KIND_IDENT, stok_pkg::ERR_NONE, 24'd0}
   };

   string keyish [10] = '{"let", "in", "lets", "le", "l", "i", "inn", "ie", "letin", "in_"};
   string ops [11] = '{"=", "==", ":", "::", "->", ";", "\\", "(", ")", "[", "]"};

   logic                                clock;
   logic                                reset;
   logic                                req_tvalid;
   logic                                req_tready;
   logic [stok_pkg::REQ_TDATA_BITS-1:0] req_tdata;
   logic                                req_tuser;
   logic                                rsp_tvalid;
   logic                                rsp_tready;
   logic [stok_pkg::RSP_TDATA_BITS-1:0] rsp_tdata;
   logic [stok_pkg::RSP_TUSER_BITS-1:0] rsp_tuser;
   logic                                rsp_tlast;

   stok_pkg::mode_type               lx_mode;
   stok_pkg::keyword_type            lx_kw;
   logic [stok_pkg::OFFSET_BITS-1:0] lx_offset;
   logic [stok_pkg::OFFSET_BITS-1:0] lx_pstart;
   logic [stok_pkg::LINE_BITS-1:0]   lx_line;
   logic [stok_pkg::LINE_BITS-1:0]   lx_pline;

   stok_pkg::result_type step_q [$];
   stok_pkg::result_type token_q [$];
   beat_type             src_q [$];

   int req_beats;
   int end_beats;
   int tokens_checked;
   int mismatches;
   int cycles;
   bit calm;
   bit kind_seen [32];

   source_tokenizer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   function automatic bit letter(logic [7:0] c);
      return (c >= stok_pkg::CH_LOWER_A && c <= stok_pkg::CH_LOWER_Z) ||
             (c >= stok_pkg::CH_UPPER_A && c <= stok_pkg::CH_UPPER_Z);
   endfunction

   function automatic bit digit(logic [7:0] c);
      return c >= stok_pkg::CH_0 && c <= stok_pkg::CH_9;
   endfunction

   function automatic void note_token(stok_pkg::token_kind_type k,
                                      stok_pkg::error_code_type e,
                                      logic [stok_pkg::FIELD_BITS-1:0] s,
                                      logic [stok_pkg::FIELD_BITS-1:0] n,
                                      logic [stok_pkg::FIELD_BITS-1:0] ln);
      stok_pkg::result_type r;
      r.kind  = k;
      r.err   = e;
      r.start = s;
      r.len   = n;
      r.line  = ln;
      r.last  = 1'b0;
      step_q.push_back(r);
   endfunction

   function automatic void bump_offset();
      if (lx_offset != stok_pkg::OFFSET_MAX) lx_offset++;
   endfunction

   function automatic void note_pending(stok_pkg::token_kind_type k,
                                        stok_pkg::error_code_type e);
      note_token(k, e, lx_pstart, lx_offset - lx_pstart, lx_pline);
   endfunction

   function automatic void open_token(stok_pkg::mode_type m);
      lx_mode   = m;
      lx_pstart = lx_offset;
      lx_pline  = lx_line;
      bump_offset();
   endfunction

   function automatic void lone_byte(stok_pkg::token_kind_type k,
                                     stok_pkg::error_code_type e);
      note_token(k, e, lx_offset, stok_pkg::FIELD_BITS'(1), lx_line);
      bump_offset();
   endfunction

   function automatic void close_pending();
      case (lx_mode)
         stok_pkg::MODE_IDENT: begin
            if (lx_kw == stok_pkg::KW_LET) note_pending(stok_pkg::KIND_LET, stok_pkg::ERR_NONE);
            else if (lx_kw == stok_pkg::KW_IN)
               note_pending(stok_pkg::KIND_IN, stok_pkg::ERR_NONE);
            else note_pending(stok_pkg::KIND_IDENT, stok_pkg::ERR_NONE);
         end
         stok_pkg::MODE_NUMBER: note_pending(stok_pkg::KIND_NUMBER, stok_pkg::ERR_NONE);
         stok_pkg::MODE_STRING: note_pending(stok_pkg::KIND_BAD, stok_pkg::ERR_UNTERM);
         stok_pkg::MODE_COLON:  note_pending(stok_pkg::KIND_COLON, stok_pkg::ERR_NONE);
         stok_pkg::MODE_EQUAL:  note_pending(stok_pkg::KIND_ASSIGN, stok_pkg::ERR_NONE);
         stok_pkg::MODE_MINUS:  note_pending(stok_pkg::KIND_BAD, stok_pkg::ERR_UNKNOWN);
         default: ;
      endcase
      lx_mode = stok_pkg::MODE_IDLE;
   endfunction

   function automatic void fresh_byte(logic [7:0] c);
      lx_mode = stok_pkg::MODE_IDLE;
      if (c == stok_pkg::CH_SPACE || (c >= stok_pkg::CH_TAB && c <= stok_pkg::CH_CR)) begin
         if (c == stok_pkg::CH_LF && lx_line != stok_pkg::LINE_MAX) lx_line++;
         bump_offset();
      end else if (letter(c) || c == stok_pkg::CH_UNDERSCORE) begin
         if (c == stok_pkg::CH_LOWER_L) lx_kw = stok_pkg::KW_L;
         else if (c == stok_pkg::CH_LOWER_I) lx_kw = stok_pkg::KW_I;
         else lx_kw = stok_pkg::KW_NONE;
         open_token(stok_pkg::MODE_IDENT);
      end else if (digit(c)) begin
         open_token(stok_pkg::MODE_NUMBER);
      end else begin
         case (c)
            stok_pkg::CH_QUOTE:     open_token(stok_pkg::MODE_STRING);
            stok_pkg::CH_COLON:     open_token(stok_pkg::MODE_COLON);
            stok_pkg::CH_EQUAL:     open_token(stok_pkg::MODE_EQUAL);
            stok_pkg::CH_MINUS:     open_token(stok_pkg::MODE_MINUS);
            stok_pkg::CH_LPAR:      lone_byte(stok_pkg::KIND_LPAREN, stok_pkg::ERR_NONE);
            stok_pkg::CH_RPAR:      lone_byte(stok_pkg::KIND_RPAREN, stok_pkg::ERR_NONE);
            stok_pkg::CH_LBRACK:    lone_byte(stok_pkg::KIND_LSQUARE, stok_pkg::ERR_NONE);
            stok_pkg::CH_RBRACK:    lone_byte(stok_pkg::KIND_RSQUARE, stok_pkg::ERR_NONE);
            stok_pkg::CH_SEMI:      lone_byte(stok_pkg::KIND_SEMI, stok_pkg::ERR_NONE);
            stok_pkg::CH_BACKSLASH: lone_byte(stok_pkg::KIND_BSLASH, stok_pkg::ERR_NONE);
            default:                lone_byte(stok_pkg::KIND_BAD, stok_pkg::ERR_UNKNOWN);
         endcase
      end
   endfunction

   // tokens caused by one accepted beat land in step_q, last flag on the final one
   function automatic void lex_beat(logic eoi, logic [7:0] c);
      logic [7:0]               want;
      stok_pkg::token_kind_type pair;
      stok_pkg::result_type     r;
      step_q.delete();
      if (eoi) begin
         close_pending();
         lx_kw     = stok_pkg::KW_NONE;
         lx_offset = '0;
         lx_line   = stok_pkg::LINE_FIRST;
      end else begin
         case (lx_mode)
            stok_pkg::MODE_IDENT: begin
               if (letter(c) || digit(c) || c == stok_pkg::CH_UNDERSCORE) begin
                  if (lx_kw == stok_pkg::KW_L && c == stok_pkg::CH_LOWER_E)
                     lx_kw = stok_pkg::KW_LE;
                  else if (lx_kw == stok_pkg::KW_LE && c == stok_pkg::CH_LOWER_T)
                     lx_kw = stok_pkg::KW_LET;
                  else if (lx_kw == stok_pkg::KW_I && c == stok_pkg::CH_LOWER_N)
                     lx_kw = stok_pkg::KW_IN;
                  else lx_kw = stok_pkg::KW_NONE;
                  bump_offset();
               end else begin
                  close_pending();
                  fresh_byte(c);
               end
            end
            stok_pkg::MODE_NUMBER: begin
               if (digit(c)) begin
                  bump_offset();
               end else begin
                  close_pending();
                  fresh_byte(c);
               end
            end
            stok_pkg::MODE_STRING: begin
               bump_offset();
               if (c == stok_pkg::CH_QUOTE) begin
                  note_pending(stok_pkg::KIND_STRING, stok_pkg::ERR_NONE);
                  lx_mode = stok_pkg::MODE_IDLE;
               end
            end
            stok_pkg::MODE_COLON, stok_pkg::MODE_EQUAL, stok_pkg::MODE_MINUS: begin
               if (lx_mode == stok_pkg::MODE_COLON) begin
                  want = stok_pkg::CH_COLON;
                  pair = stok_pkg::KIND_DCOLON;
               end else if (lx_mode == stok_pkg::MODE_EQUAL) begin
                  want = stok_pkg::CH_EQUAL;
                  pair = stok_pkg::KIND_EQUALS;
               end else begin
                  want = stok_pkg::CH_GT;
                  pair = stok_pkg::KIND_ARROW;
               end
               if (c == want) begin
                  bump_offset();
                  note_pending(pair, stok_pkg::ERR_NONE);
                  lx_mode = stok_pkg::MODE_IDLE;
               end else begin
                  close_pending();
                  fresh_byte(c);
               end
            end
            default: fresh_byte(c);
         endcase
      end
      if (step_q.size() != 0) begin
         r = step_q.pop_back();
         r.last = 1'b1;
         step_q.push_back(r);
      end
   endfunction

   function automatic void add_beat(logic eoi, logic [7:0] c);
      beat_type b;
      b = '{eoi, c, 1'b0, stok_pkg::KIND_IDENT, stok_pkg::ERR_NONE, '0};
      src_q.push_back(b);
   endfunction

   function automatic logic [7:0] id_char(bit lead);
      int k;
      k = $urandom_range(0, lead ? 52 : 62);
      if (k < 26) return 8'(stok_pkg::CH_LOWER_A + k);
      else if (k < 52) return 8'(stok_pkg::CH_UPPER_A + k - 26);
      else if (k == 52) return stok_pkg::CH_UNDERSCORE;
      else return 8'(stok_pkg::CH_0 + k - 53);
   endfunction

   function automatic logic [7:0] blank_char();
      int k;
      k = $urandom_range(0, 5);
      return (k == 5) ? stok_pkg::CH_SPACE : 8'(stok_pkg::CH_TAB + k);
   endfunction

   // one token-shaped run of bytes, sometimes noise or a broken one
   function automatic void add_lexeme();
      int         pick;
      int         n;
      string      w;
      logic [7:0] c;
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
         w = keyish[$urandom_range(0, 9)];
         for (int i = 0; i < w.len(); i++) add_beat(stok_pkg::ITEM_BYTE, w[i]);
      end else if (pick < 30) begin
         n = $urandom_range(0, 5);
         add_beat(stok_pkg::ITEM_BYTE, id_char(1'b1));
         for (int i = 0; i < n; i++) add_beat(stok_pkg::ITEM_BYTE, id_char(1'b0));
      end else if (pick < 42) begin
         n = $urandom_range(1, 5);
         for (int i = 0; i < n; i++)
            add_beat(stok_pkg::ITEM_BYTE, 8'(stok_pkg::CH_0 + $urandom_range(0, 9)));
      end else if (pick < 52) begin
         add_beat(stok_pkg::ITEM_BYTE, stok_pkg::CH_QUOTE);
         n = $urandom_range(0, 6);
         for (int i = 0; i < n; i++) begin
            c = ($urandom_range(0, 3) == 0) ? stok_pkg::CH_LF : 8'($urandom_range(0, 255));
            if (c == stok_pkg::CH_QUOTE) c = stok_pkg::CH_SPACE;
            add_beat(stok_pkg::ITEM_BYTE, c);
         end
         if (pick < 50) add_beat(stok_pkg::ITEM_BYTE, stok_pkg::CH_QUOTE);
         else add_beat(stok_pkg::ITEM_END, 8'($urandom_range(0, 255)));
      end else if (pick < 72) begin
         w = ops[$urandom_range(0, 10)];
         for (int i = 0; i < w.len(); i++) add_beat(stok_pkg::ITEM_BYTE, w[i]);
      end else if (pick < 84) begin
         n = $urandom_range(1, 3);
         for (int i = 0; i < n; i++) add_beat(stok_pkg::ITEM_BYTE, blank_char());
      end else if (pick < 92) begin
         add_beat(stok_pkg::ITEM_BYTE, 8'($urandom_range(0, 255)));
      end else if (pick < 96) begin
         add_beat(stok_pkg::ITEM_BYTE, stok_pkg::CH_MINUS);
      end else begin
         add_beat(stok_pkg::ITEM_END, 8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 1) == 0) add_beat(stok_pkg::ITEM_BYTE, blank_char());
   endfunction

   initial begin : stimulus
      beat_type             row;
      stok_pkg::result_type r;
      int                   kinds_hit;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = stok_pkg::ITEM_BYTE;
      lx_mode    = stok_pkg::MODE_IDLE;
      lx_kw      = stok_pkg::KW_NONE;
      lx_offset  = '0;
      lx_line    = stok_pkg::LINE_FIRST;
      lx_pstart  = '0;
      lx_pline   = stok_pkg::LINE_FIRST;
      for (int i = 0; i < SCRIPT_ROWS; i++) src_q.push_back(SCRIPT[i]);
      while (src_q.size() < SCRIPT_ROWS + RANDOM_BEATS) add_lexeme();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < src_q.size(); i++) begin
         row  = src_q[i];
         calm = (i >= src_q.size() - CALM_BEATS);
         if (i == SCRIPT_ROWS || i == PAUSE_AT) begin
            req_tvalid <= 1'b0;
            @(negedge clock);
            while (token_q.size() != 0) @(negedge clock);
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata  <= row.ch;
         req_tuser  <= row.eoi;
         @(posedge clock);
         while (!req_tready) @(posedge clock);
         lex_beat(row.eoi, row.ch);
         if (row.typed) begin
            r = '{row.kind, row.err, row.start, stok_pkg::FIELD_BITS'(1),
                  stok_pkg::LINE_FIRST, 1'b1};
            token_q.push_back(r);
         end else begin
            foreach (step_q[k]) token_q.push_back(step_q[k]);
         end
         req_beats++;
         if (row.eoi) end_beats++;
         @(negedge clock);
      end
      req_tvalid <= 1'b0;
      while (token_q.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      kinds_hit = 0;
      for (int k = 0; k <= stok_pkg::KIND_BAD; k++) kinds_hit += kind_seen[k];
      $display("%0d source beats sent (%0d end of input), %0d tokens checked, %0d mismatches",
               req_beats, end_beats, tokens_checked, mismatches);
      $display("%0d of %0d token kinds seen, with idling, a long rsp hold and drained pauses",
               kinds_hit, stok_pkg::KIND_BAD + 1);
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin : receiver
      bit held;
      held       = 1'b0;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      rsp_tready <= 1'b1;
      forever begin
         @(negedge clock);
         if (!held && req_beats >= HOLD_AT) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            rsp_tready <= 1'b1;
         end else if (!calm && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clock);
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : token_check
      stok_pkg::result_type seen;
      stok_pkg::result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen.kind  = stok_pkg::token_kind_type'(rsp_tuser);
         seen.err   = stok_pkg::error_code_type'(rsp_tdata[1:0]);
         seen.start = rsp_tdata[25:2];
         seen.len   = rsp_tdata[49:26];
         seen.line  = rsp_tdata[73:50];
         seen.last  = rsp_tlast;
         kind_seen[rsp_tuser] = 1'b1;
         if (token_q.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("unexpected token beat: kind %0d start %0d len %0d line %0d",
                        rsp_tuser, seen.start, seen.len, seen.line);
         end else begin
            want = token_q.pop_front();
            tokens_checked++;
            if (seen.kind != want.kind || seen.err != want.err || seen.start != want.start ||
                seen.len != want.len || seen.line != want.line || seen.last != want.last ||
                rsp_tdata[79:74] != '0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display({"token %0d mismatch (expected/actual): kind %0d/%0d err %0d/%0d ",
                            "start %0d/%0d len %0d/%0d line %0d/%0d last %0b/%0b pad %0h"},
                           tokens_checked, want.kind, seen.kind, want.err, seen.err,
                           want.start, seen.start, want.len, seen.len, want.line, seen.line,
                           want.last, seen.last, rsp_tdata[79:74]);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d tokens outstanding", cycles, token_q.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

endmodule

@@ sim.f @@
hw/rtl/stok_pkg.sv
hw/rtl/stok_lexer.sv
hw/rtl/source_tokenizer.sv
hw/rtl/stok_checker.sv
sim/tb_source_tokenizer.sv
